// File: design/rv32sc_pkg.sv
// ----------------------------------------------------------------------------
// rv32sc_pkg
// Shared constants, instruction encodings and inter-module types for the
// RV32 subset core.
// ----------------------------------------------------------------------------
package rv32sc_pkg;

  localparam int unsigned XLEN          = 32;
  localparam int unsigned REG_AW        = 5;
  localparam int unsigned NUM_REGS      = 32;
  localparam int unsigned MEM_ADDR_W    = 12;
  localparam int unsigned MEM_WORDS_DEF = 4096;

  // major opcodes
  localparam logic [6:0] OP_RTYPE  = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_EXIT   = 7'h00;

  // funct3 / funct7
  localparam logic [2:0] F3_ADD_SUB = 3'b000;
  localparam logic [2:0] F3_XOR     = 3'b100;
  localparam logic [2:0] F3_SRA     = 3'b101;
  localparam logic [2:0] F3_ADDI    = 3'b000;
  localparam logic [2:0] F3_ANDI    = 3'b111;
  localparam logic [2:0] F3_LW      = 3'b010;
  localparam logic [2:0] F3_SW      = 3'b010;
  localparam logic [2:0] F3_BLT     = 3'b100;
  localparam logic [2:0] F3_JALR    = 3'b000;
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;

  // execute stage outcome for one instruction
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              halt_set;
    logic              illegal;
    logic              reg_we;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   value;
    logic              is_load;
    logic              mem_re;
    logic              mem_we;
    logic [XLEN-1:0]   mem_addr;
    logic [XLEN-1:0]   mem_value;
    logic              rtype_inc;
  } ex_res_t;

  // register file write port
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

// File: design/rv32sc_regfile.sv
// ----------------------------------------------------------------------------
// rv32sc_regfile
// 32 x 32 register file: one write port, two registered read ports with
// write-through bypass. Valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module rv32sc_regfile (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [rv32sc_pkg::REG_AW-1:0]    rs1_i,
  input  logic [rv32sc_pkg::REG_AW-1:0]    rs2_i,
  input  rv32sc_pkg::rf_wr_t               wr_i,
  output logic [rv32sc_pkg::XLEN-1:0]      rdata1_o,
  output logic [rv32sc_pkg::XLEN-1:0]      rdata2_o
);
  import rv32sc_pkg::*;

  logic [XLEN-1:0]     mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [XLEN-1:0]     rdata1_q, rdata2_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.we) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // x0 is never written, so its valid bit stays clear and it reads zero
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.we && wr_i.addr == rs1_i) begin
        rdata1_q <= wr_i.data;
      end else if (vld_q[rs1_i]) begin
        rdata1_q <= mem_q[rs1_i];
      end else begin
        rdata1_q <= '0;
      end
      if (wr_i.we && wr_i.addr == rs2_i) begin
        rdata2_q <= wr_i.data;
      end else if (vld_q[rs2_i]) begin
        rdata2_q <= mem_q[rs2_i];
      end else begin
        rdata2_q <= '0;
      end
    end
  end

  assign rdata1_o = rdata1_q;
  assign rdata2_o = rdata2_q;

endmodule

// File: design/rv32sc_dmem.sv
// ----------------------------------------------------------------------------
// rv32sc_dmem
// Word-addressed data memory, one port, registered read data. After reset
// a sweep zeroes every word, one per cycle, while busy_o is high.
// ----------------------------------------------------------------------------
module rv32sc_dmem #(
  parameter int unsigned MEM_WORDS = rv32sc_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          re_i,
  input  logic                          we_i,
  input  logic [$clog2(MEM_WORDS)-1:0]  addr_i,
  input  logic [rv32sc_pkg::XLEN-1:0]   wdata_i,
  output logic [rv32sc_pkg::XLEN-1:0]   rdata_o,
  output logic                          busy_o
);
  import rv32sc_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [XLEN-1:0] mem_q [MEM_WORDS];
  logic [XLEN-1:0] rdata_q;
  logic            clr_busy_q;
  logic [AW-1:0]   clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

// File: design/rv32sc_exec.sv
// ----------------------------------------------------------------------------
// rv32sc_exec
// Decode and execute for one instruction: ALU, branch compare, next PC,
// effective address. Load data is merged later in the result stage.
// ----------------------------------------------------------------------------
module rv32sc_exec (
  input  logic [rv32sc_pkg::XLEN-1:0] instr_i,
  input  logic [rv32sc_pkg::XLEN-1:0] pc_i,
  input  logic [rv32sc_pkg::XLEN-1:0] opa_i,
  input  logic [rv32sc_pkg::XLEN-1:0] opb_i,
  input  logic                        halted_i,
  output rv32sc_pkg::ex_res_t         res_o
);
  import rv32sc_pkg::*;

  logic [6:0]        op;
  logic [REG_AW-1:0] rd;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [XLEN-1:0]   imm_i, imm_s, imm_b, pc_plus4;

  assign op       = instr_i[6:0];
  assign rd       = instr_i[11:7];
  assign f3       = instr_i[14:12];
  assign f7       = instr_i[31:25];
  assign imm_i    = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s    = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b    = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                     instr_i[11:8], 1'b0};
  assign pc_plus4 = pc_i + XLEN'(4);

  always_comb begin
    res_o         = '0;
    res_o.next_pc = pc_plus4;
    if (halted_i) begin
      res_o.next_pc = pc_i;
    end else begin
      case (op)
        OP_RTYPE: begin
          res_o.reg_we    = 1'b1;
          res_o.rtype_inc = 1'b1;
          if (f3 == F3_ADD_SUB && f7 == F7_BASE) begin
            res_o.value = opa_i + opb_i;
          end else if (f3 == F3_ADD_SUB && f7 == F7_ALT) begin
            res_o.value = opa_i - opb_i;
          end else if (f3 == F3_XOR && f7 == F7_BASE) begin
            res_o.value = opa_i ^ opb_i;
          end else if (f3 == F3_SRA && f7 == F7_ALT) begin
            res_o.value = $unsigned($signed(opa_i) >>> opb_i[4:0]);
          end else begin
            res_o.illegal   = 1'b1;
            res_o.reg_we    = 1'b0;
            res_o.rtype_inc = 1'b0;
          end
        end
        OP_IMM: begin
          if (f3 == F3_ADDI) begin
            res_o.reg_we = 1'b1;
            res_o.value  = opa_i + imm_i;
          end else if (f3 == F3_ANDI) begin
            res_o.reg_we = 1'b1;
            res_o.value  = opa_i & imm_i;
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        OP_LOAD: begin
          if (f3 == F3_LW) begin
            res_o.reg_we   = 1'b1;
            res_o.is_load  = 1'b1;
            res_o.mem_re   = 1'b1;
            res_o.mem_addr = opa_i + imm_i;
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        OP_STORE: begin
          if (f3 == F3_SW) begin
            res_o.mem_we    = 1'b1;
            res_o.mem_addr  = opa_i + imm_s;
            res_o.mem_value = opb_i;
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        OP_BRANCH: begin
          if (f3 == F3_BLT) begin
            if ($signed(opa_i) < $signed(opb_i)) begin
              res_o.next_pc = pc_i + imm_b;
            end
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        OP_JALR: begin
          if (f3 == F3_JALR) begin
            res_o.reg_we  = 1'b1;
            res_o.value   = pc_plus4;
            res_o.next_pc = (opa_i + imm_i) & ~XLEN'(1);
          end else begin
            res_o.illegal = 1'b1;
          end
        end
        OP_EXIT: begin
          res_o.halt_set = 1'b1;
          res_o.next_pc  = pc_i;
        end
        default: begin
          res_o.illegal = 1'b1;
        end
      endcase
    end

    // x0 destination: drop the write entirely
    if (res_o.reg_we && rd != '0) begin
      res_o.rd = rd;
    end else begin
      res_o.reg_we  = 1'b0;
      res_o.is_load = 1'b0;
      res_o.value   = '0;
    end
  end

endmodule

// File: design/rv32_subset_single_cycle_core.sv
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core
// RV32 subset core (ADD SUB XOR SRA ADDI ANDI LW SW BLT JALR EXIT) that
// executes one fetched instruction word per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o / instr_word_i. Feed the word
//   fetched at next_pc_o of the previous result (0 after reset).
//   Output channel: out_valid_o / out_stall_i plus one port per result field.
//   A request is held in the execute register, then in the result register.
//   Throughput: one instruction per cycle unless stalled; register operands
//   of a following instruction are forwarded from the result register, load
//   data included. The data memory has one port: one load or store per cycle.
//   Reset: pc, registers, counter and halt flag clear at once; the data
//   memory is then zeroed word by word, with in_stall_o held high.
//   Stall: while out_stall_i holds a result, one more request can be taken
//   into the execute register, then in_stall_o rises.
//   After EXIT every request returns the held pc with halted_o set.
//   MEM_WORDS must be a power of two (unchecked); addresses use low log2 bits.
// ----------------------------------------------------------------------------
module rv32_subset_single_cycle_core #(
  parameter int unsigned MEM_WORDS = rv32sc_pkg::MEM_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rv32sc_pkg::XLEN-1:0]         instr_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rv32sc_pkg::XLEN-1:0]         next_pc_o,
  output logic                                halted_o,
  output logic                                illegal_o,
  output logic                                reg_we_o,
  output logic [rv32sc_pkg::REG_AW-1:0]       reg_index_o,
  output logic signed [rv32sc_pkg::XLEN-1:0]  reg_value_o,
  output logic                                mem_we_o,
  output logic [rv32sc_pkg::MEM_ADDR_W-1:0]   mem_addr_o,
  output logic signed [rv32sc_pkg::XLEN-1:0]  mem_value_o,
  output logic [rv32sc_pkg::XLEN-1:0]         rtype_count_o
);
  import rv32sc_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // execute stage
  logic            ex_valid_q;
  logic [XLEN-1:0] instr_q, pc_q, rcnt_q, rcnt_d;
  logic            halt_q;

  // result stage
  logic                  out_valid_q;
  logic [XLEN-1:0]       wb_npc_q, wb_val_q, wb_mval_q, wb_rcnt_q;
  logic                  wb_halted_q, wb_ill_q, wb_we_q, wb_load_q, wb_mwe_q;
  logic [REG_AW-1:0]     wb_rd_q;
  logic [MEM_ADDR_W-1:0] wb_maddr_q;

  logic            clr_busy, wb_ready, ex_adv, in_acc, wb_leave;
  logic            dm_re, dm_we;
  logic [AW-1:0]   dm_addr;
  logic [XLEN-1:0] maddr_ext, rs1_rd, rs2_rd, ld_data, wb_value, opa, opb;
  rf_wr_t          rf_wr;
  ex_res_t         ex_res;

  assign wb_ready   = !out_valid_q || !out_stall_i;
  assign ex_adv     = ex_valid_q && wb_ready;
  assign in_stall_o = clr_busy || (ex_valid_q && !wb_ready);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wb_leave   = out_valid_q && !out_stall_i;

  assign wb_value   = wb_load_q ? ld_data : wb_val_q;

  // architectural register write happens when the result is taken
  assign rf_wr.we   = wb_leave && wb_we_q;
  assign rf_wr.addr = wb_rd_q;
  assign rf_wr.data = wb_value;

  rv32sc_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc),
    .rs1_i    (instr_word_i[19:15]),
    .rs2_i    (instr_word_i[24:20]),
    .wr_i     (rf_wr),
    .rdata1_o (rs1_rd),
    .rdata2_o (rs2_rd)
  );

  // forward the pending write held in the result register
  assign opa = (out_valid_q && wb_we_q && wb_rd_q == instr_q[19:15]) ? wb_value : rs1_rd;
  assign opb = (out_valid_q && wb_we_q && wb_rd_q == instr_q[24:20]) ? wb_value : rs2_rd;

  rv32sc_exec u_exec (
    .instr_i  (instr_q),
    .pc_i     (pc_q),
    .opa_i    (opa),
    .opb_i    (opb),
    .halted_i (halt_q),
    .res_o    (ex_res)
  );

  assign dm_addr   = ex_res.mem_addr[AW-1:0];
  assign dm_re     = ex_adv && ex_res.mem_re;
  assign dm_we     = ex_adv && ex_res.mem_we;
  assign maddr_ext = {{(XLEN - AW){1'b0}}, dm_addr};

  rv32sc_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (dm_re),
    .we_i    (dm_we),
    .addr_i  (dm_addr),
    .wdata_i (ex_res.mem_value),
    .rdata_o (ld_data),
    .busy_o  (clr_busy)
  );

  assign rcnt_d = rcnt_q + XLEN'(ex_res.rtype_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      rcnt_q      <= '0;
    end else begin
      if (in_acc) begin
        ex_valid_q <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_adv) begin
        out_valid_q <= 1'b1;
        pc_q        <= ex_res.next_pc;
        rcnt_q      <= rcnt_d;
        if (ex_res.halt_set) begin
          halt_q <= 1'b1;
        end
      end else if (wb_leave) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      instr_q <= instr_word_i;
    end
    if (ex_adv) begin
      wb_npc_q    <= ex_res.next_pc;
      wb_halted_q <= halt_q || ex_res.halt_set;
      wb_ill_q    <= ex_res.illegal;
      wb_we_q     <= ex_res.reg_we;
      wb_rd_q     <= ex_res.rd;
      wb_val_q    <= ex_res.value;
      wb_load_q   <= ex_res.is_load;
      wb_mwe_q    <= ex_res.mem_we;
      wb_maddr_q  <= ex_res.mem_we ? maddr_ext[MEM_ADDR_W-1:0] : '0;
      wb_mval_q   <= ex_res.mem_value;
      wb_rcnt_q   <= rcnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = wb_npc_q;
  assign halted_o      = wb_halted_q;
  assign illegal_o     = wb_ill_q;
  assign reg_we_o      = wb_we_q;
  assign reg_index_o   = wb_rd_q;
  assign reg_value_o   = $signed(wb_value);
  assign mem_we_o      = wb_mwe_q;
  assign mem_addr_o    = wb_maddr_q;
  assign mem_value_o   = $signed(wb_mval_q);
  assign rtype_count_o = wb_rcnt_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> (!ex_valid_q && !out_valid_q))
    else $error("request in flight during memory clear");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reg_we_o) |-> (reg_index_o != '0))
    else $error("result writes x0");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && halted_o) |-> (!reg_we_o && !mem_we_o && !illegal_o))
    else $error("halted result carries a write or illegal flag");

  a_halt_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_adv && halt_q) |=> (next_pc_o == $past(pc_q)))
    else $error("pc moved while halted");

endmodule
